[rtl/rfp_pkg.sv]
// shared types and constants of the response frame parser
`default_nettype none

package rfp_pkg;

   localparam logic [7:0] READY_BYTE  = 8'h01;
   localparam logic [7:0] START_ZERO  = 8'h00;
   localparam logic [7:0] START_FF    = 8'hFF;
   localparam logic [7:0] DIR_TO_HOST = 8'hD5;
   localparam logic [7:0] POSTAMBLE   = 8'h00;

   // csr register indexes
   localparam logic CSR_EXPECTED_COMMAND   = 1'b0;
   localparam logic CSR_MAX_PAYLOAD_LENGTH = 1'b1;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_NOT_READY   = 4'd1,
      ST_BAD_START   = 4'd2,
      ST_LENGTH_CHK  = 4'd3,
      ST_TOO_SHORT   = 4'd4,
      ST_DIRECTION   = 4'd5,
      ST_CODE        = 4'd6,
      ST_TOO_LONG    = 4'd7,
      ST_DATA_CHK    = 4'd8,
      ST_POSTAMBLE   = 4'd9
   } status_type;

   // one finished frame handed from the front to the back
   typedef struct packed {
      status_type status;
      logic [7:0] count;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SHOW
   } back_state_type;

endpackage

`default_nettype wire

[rtl/rfp_if.sv]
// request and response channel interfaces
`default_nettype none

interface rfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       starts_read;

   modport source (output valid, rx_byte, starts_read, input ready);
   modport sink (input valid, rx_byte, starts_read, output ready);
endinterface

interface rfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       has_byte;
   logic [3:0] status;
   logic       last_of_run;

   modport source (output valid, payload_byte, has_byte, status, last_of_run, input ready);
   modport sink (input valid, payload_byte, has_byte, status, last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/response_frame_parser_top.sv]
// top level of the response frame parser
`default_nettype none

// The parser takes a reader response one request at a time (one byte, with
// starts_read on the first byte of a frame) and checks ready byte, preamble,
// length and its check byte, direction, response code against
// expected_command + 1, payload limit, data checksum and postamble, in that
// order. The first failed check gives one response with its status code and
// last_of_run set; a good frame gives one response per payload byte, the last
// one marked, or a single empty response when the payload is empty. Bytes
// outside an open frame are dropped without a response. The front accepts one
// byte per cycle and writes payload bytes into a store of FRAME_BYTES - 10
// entries; finished frames go through a two-entry job queue to the back,
// which reads the store and drives the response channel. Each payload
// response is a store read followed by its output; an error or empty
// response is shown without a read once the job reaches the back. While a
// good frame's payload is still being sent the front holds off new requests,
// since the store holds only one payload; error frames queue up and hold off
// requests only while both queue entries are taken.
// Configuration writes take effect on the next cycle and must be done while
// the block is idle.

module response_frame_parser_top
   import rfp_pkg::*;
#(
   parameter int FRAME_BYTES = 48
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rfp_req_if.sink         req_ch,
   rfp_rsp_if.source       rsp_ch,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_write_data
);

   // store depth, kept at two or more so the address has at least one bit
   localparam int StoreDepth = FRAME_BYTES - 10;
   localparam int RamDepth   = StoreDepth > 2 ? StoreDepth : 2;
   localparam int AW         = $clog2(RamDepth);

   // configuration registers
   logic [7:0] expected_command_ff;
   logic [5:0] max_payload_length_ff;

   // front to queue
   logic    job_push;
   job_type job;

   // queue to back
   job_type head;
   logic    q_empty;
   logic    q_full;
   logic    q_pop;
   logic    payload_done;

   // payload store ports
   logic          st_wr_en;
   logic [AW-1:0] st_wr_addr;
   logic [7:0]    st_wr_data;
   logic          st_rd_en;
   logic [AW-1:0] st_rd_addr;
   logic [7:0]    st_rd_data;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_command_ff   <= 8'd0;
         max_payload_length_ff <= 6'd38;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_EXPECTED_COMMAND: begin
               expected_command_ff <= csr_write_data;
            end
            CSR_MAX_PAYLOAD_LENGTH: begin
               max_payload_length_ff <= csr_write_data[5:0];
            end
            default: begin
               expected_command_ff <= expected_command_ff;
            end
         endcase
      end
   end

   // byte checker and payload writer
   rfp_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .AW          (AW)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_ch.valid),
      .in_ready           (req_ch.ready),
      .rx_byte            (req_ch.rx_byte),
      .starts_read        (req_ch.starts_read),
      .expected_command   (expected_command_ff),
      .max_payload_length (max_payload_length_ff),
      .q_full             (q_full),
      .payload_done       (payload_done),
      .job_push           (job_push),
      .job                (job),
      .st_wr_en           (st_wr_en),
      .st_wr_addr         (st_wr_addr),
      .st_wr_data         (st_wr_data)
   );

   // finished frames waiting for the back
   rfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // payload store
   rfp_ram #(
      .WIDTH (8),
      .DEPTH (RamDepth)
   ) u_store (
      .clock      (clock),
      .wr_en      (st_wr_en),
      .wr_addr    (st_wr_addr),
      .wr_data    (st_wr_data),
      .rd_en      (st_rd_en),
      .rd_addr    (st_rd_addr),
      .rd_data_ff (st_rd_data)
   );

   // response generator
   rfp_back #(
      .AW (AW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .payload_done (payload_done),
      .st_rd_en     (st_rd_en),
      .st_rd_addr   (st_rd_addr),
      .st_rd_data   (st_rd_data),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .payload_byte (rsp_ch.payload_byte),
      .has_byte     (rsp_ch.has_byte),
      .status       (rsp_ch.status),
      .last_of_run  (rsp_ch.last_of_run)
   );

endmodule

`default_nettype wire

[rtl/rfp_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module rfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 38
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/rfp_front.sv]
// front: checks incoming bytes, stores the payload, posts one job per frame
`default_nettype none

module rfp_front
   import rfp_pkg::*;
#(
   parameter int FRAME_BYTES = 48,
   parameter int AW          = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [7:0]    rx_byte,
   input  wire logic          starts_read,
   input  wire logic [7:0]    expected_command,
   input  wire logic [5:0]    max_payload_length,
   input  wire logic          q_full,
   input  wire logic          payload_done,
   output logic               job_push,
   output job_type            job,
   output logic               st_wr_en,
   output logic [AW-1:0]      st_wr_addr,
   output logic [7:0]         st_wr_data
);

   localparam int StoreDepth = FRAME_BYTES - 10;
   localparam int PW = $clog2(FRAME_BYTES);
   localparam int CW = (PW > 8 ? PW : 8) + 1;

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic          finished_ff, finished_in;
   logic          pend_ff, pend_in;

   logic          accept;
   logic          open;
   logic [PW-1:0] pos_cur;
   logic [CW-1:0] pos_x, len_x, limit_x, mpl_x;
   logic [7:0]    len_cur, sum_cur, sum_add;
   logic [7:0]    cmd_next;
   logic [PW-1:0] idx;

   assign in_ready = !q_full && !pend_ff;
   assign accept   = in_valid && in_ready;
   assign open     = starts_read || !finished_ff;
   assign pos_cur  = starts_read ? '0 : pos_ff;
   assign len_cur  = starts_read ? 8'd0 : len_ff;
   assign sum_cur  = starts_read ? 8'd0 : sum_ff;
   assign sum_add  = sum_cur + rx_byte;
   assign cmd_next = expected_command + 8'd1;
   assign pos_x    = CW'(pos_cur);
   assign len_x    = CW'(len_cur);
   assign mpl_x    = CW'(max_payload_length);
   assign limit_x  = (mpl_x > CW'(StoreDepth)) ? CW'(StoreDepth) : mpl_x;
   assign idx      = pos_cur - PW'(8);

   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      finished_in = finished_ff;
      pend_in     = pend_ff && !payload_done;
      job_push    = 1'b0;
      job.status  = ST_OK;
      job.count   = 8'd0;
      st_wr_en    = 1'b0;
      st_wr_addr  = idx[AW-1:0];
      st_wr_data  = rx_byte;

      if (accept && open) begin
         pos_in      = pos_cur + PW'(1);
         len_in      = len_cur;
         sum_in      = sum_cur;
         finished_in = 1'b0;
         case (pos_cur)
            PW'(0): begin
               if (rx_byte != READY_BYTE) begin
                  job_push = 1'b1;
                  job.status = ST_NOT_READY;
               end
            end
            PW'(1), PW'(2): begin
               if (rx_byte != START_ZERO) begin
                  job_push = 1'b1;
                  job.status = ST_BAD_START;
               end
            end
            PW'(3): begin
               if (rx_byte != START_FF) begin
                  job_push = 1'b1;
                  job.status = ST_BAD_START;
               end
            end
            PW'(4): begin
               len_in = rx_byte;
            end
            PW'(5): begin
               if (8'(len_cur + rx_byte) != 8'd0) begin
                  job_push = 1'b1;
                  job.status = ST_LENGTH_CHK;
               end else if (len_cur < 8'd2) begin
                  job_push = 1'b1;
                  job.status = ST_TOO_SHORT;
               end
            end
            PW'(6): begin
               sum_in = rx_byte;
               if (rx_byte != DIR_TO_HOST) begin
                  job_push = 1'b1;
                  job.status = ST_DIRECTION;
               end
            end
            PW'(7): begin
               sum_in = sum_add;
               if (rx_byte != cmd_next) begin
                  job_push = 1'b1;
                  job.status = ST_CODE;
               end else if (len_x - CW'(2) > limit_x) begin
                  job_push = 1'b1;
                  job.status = ST_TOO_LONG;
               end
            end
            default: begin
               sum_in = sum_add;
               if (pos_x < len_x + CW'(6)) begin
                  st_wr_en = 1'b1;
               end else if (pos_x == len_x + CW'(6)) begin
                  if (sum_add != 8'd0) begin
                     job_push = 1'b1;
                     job.status = ST_DATA_CHK;
                  end
               end else begin
                  job_push = 1'b1;
                  if (rx_byte != POSTAMBLE) begin
                     job.status = ST_POSTAMBLE;
                  end else begin
                     job.count = len_cur - 8'd2;
                     pend_in   = (job.count != 8'd0);
                  end
               end
            end
         endcase
         if (job_push) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff <= 1'b1;
         pend_ff     <= 1'b0;
         pos_ff      <= '0;
         len_ff      <= 8'd0;
         sum_ff      <= 8'd0;
      end else begin
         finished_ff <= finished_in;
         pend_ff     <= pend_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rfp_queue.sv]
// two-entry job queue between front and back
`default_nettype none

module rfp_queue
   import rfp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty,
   output logic         full
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rfp_back.sv]
// back: turns queued jobs into responses, reading the payload from the store
`default_nettype none

module rfp_back
   import rfp_pkg::*;
#(
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire job_type       head,
   input  wire logic          q_empty,
   output logic               q_pop,
   output logic               payload_done,
   output logic               st_rd_en,
   output logic [AW-1:0]      st_rd_addr,
   input  wire logic [7:0]    st_rd_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [7:0]         payload_byte,
   output logic               has_byte,
   output logic [3:0]         status,
   output logic               last_of_run
);

   back_state_type state_ff, state_in;
   logic [7:0]     k_ff, k_in;
   logic           data_ff, data_in;
   logic           last;

   assign last         = !data_ff || (k_ff + 8'd1 == head.count);
   assign out_valid    = (state_ff == BK_SHOW);
   assign payload_byte = data_ff ? st_rd_data : 8'd0;
   assign has_byte     = data_ff;
   assign status       = head.status;
   assign last_of_run  = last;
   assign st_rd_addr   = k_in[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      data_in      = data_ff;
      q_pop        = 1'b0;
      payload_done = 1'b0;
      st_rd_en     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            k_in = 8'd0;
            if (!q_empty) begin
               if (head.status != ST_OK || head.count == 8'd0) begin
                  data_in  = 1'b0;
                  state_in = BK_SHOW;
               end else begin
                  data_in  = 1'b1;
                  st_rd_en = 1'b1;
                  state_in = BK_FETCH;
               end
            end
         end
         BK_FETCH: begin
            state_in = BK_SHOW;
         end
         BK_SHOW: begin
            if (out_ready) begin
               if (last) begin
                  q_pop        = 1'b1;
                  payload_done = data_ff;
                  state_in     = BK_IDLE;
               end else begin
                  k_in     = k_ff + 8'd1;
                  st_rd_en = 1'b1;
                  state_in = BK_FETCH;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         k_ff     <= 8'd0;
         data_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         data_ff  <= data_in;
      end
   end

endmodule

`default_nettype wire
